// ===== rtl/cpc_pkg.sv =====
`default_nettype none

package cpc_pkg;

    // Number of configured packet kinds that take part in the ID match.
    localparam int unsigned NumKinds = 5;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned CrcW    = 16;
    localparam int unsigned CountW  = 9;
    localparam int unsigned CfgW    = 40;
    localparam int unsigned StatusW = 3;
    localparam int unsigned KindW   = 3;

    // Saturation limits of the byte counter and the reported length.
    localparam logic [CountW-1:0] CountMax  = 9'd511;
    localparam logic [CountW-1:0] LengthMax = 9'd255;
    localparam logic [ByteW-1:0]  ByteMask  = 8'hFF;

    // Reset value of the polynomial register (reflected Kermit polynomial).
    localparam logic [CrcW-1:0] CrcPolyReset = 16'h8408;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_CRC_POLY     = 2'd0,
        CFG_KIND_IDS     = 2'd1,
        CFG_KIND_LENGTHS = 2'd2
    } t_cfg_index;

    // Result status codes.
    typedef enum logic [StatusW-1:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_CRC      = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_LENGTH   = 3'd4,
        ST_OVERSIZE = 3'd5
    } t_status;

    // One result transaction, first field in the highest bits.
    typedef struct packed {
        logic [CrcW-1:0]    computed_crc;
        logic [ByteW-1:0]   id_byte;
        logic [ByteW-1:0]   packet_length;
        logic [KindW-1:0]   packet_kind;
        logic [StatusW-1:0] status;
    } t_result;

    localparam int unsigned ResultW = $bits(t_result);
    localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

    // One byte through the reflected CRC-16, one bit per step.
    function automatic logic [CrcW-1:0] crc_feed(
        input logic [CrcW-1:0]  crc_in,
        input logic [ByteW-1:0] data,
        input logic [CrcW-1:0]  poly
    );
        logic [CrcW-1:0] crc;
        crc = crc_in ^ {{(CrcW-ByteW){1'b0}}, data};
        for (int k = 0; k < ByteW; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ poly;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cpc_frame_engine.sv =====
`default_nettype none

module cpc_frame_engine (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration writes.
    input  wire                                i_cfg_wr_en,
    input  wire  [1:0]                         i_cfg_index,
    input  wire  [cpc_pkg::CfgW-1:0]           i_cfg_data,
    // Accepted input transaction.
    input  wire                                i_in_accept,
    input  wire  [cpc_pkg::ByteW-1:0]          i_in_byte,
    input  wire                                i_in_last,
    // A final byte sits in the input register and will push a result.
    output logic                               o_pending,
    // Result towards the output queue.
    output logic                               o_push,
    output cpc_pkg::t_result                   o_result
);

    // Configuration registers.
    logic [cpc_pkg::CrcW-1:0] r_crc_poly;
    logic [cpc_pkg::CfgW-1:0] r_kind_ids;
    logic [cpc_pkg::CfgW-1:0] r_kind_lengths;

    // Input register.
    logic                      r_in_valid;
    logic [cpc_pkg::ByteW-1:0] r_in_byte;
    logic                      r_in_last;

    // Per-packet state.
    logic [cpc_pkg::CrcW-1:0]   r_crc;
    logic [cpc_pkg::CountW-1:0] r_count;
    logic [cpc_pkg::ByteW-1:0]  r_held0;
    logic [cpc_pkg::ByteW-1:0]  r_held1;
    logic [cpc_pkg::ByteW-1:0]  r_first;

    logic [cpc_pkg::CrcW-1:0]   n_crc;
    logic [cpc_pkg::CountW-1:0] n_count;
    logic [cpc_pkg::ByteW-1:0]  n_first;

    logic                         kind_found;
    logic [cpc_pkg::KindW-1:0]    kind_idx;
    logic [cpc_pkg::ByteW-1:0]    kind_len;
    logic                         crc_match;
    cpc_pkg::t_status             status;

    // Configuration register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_poly     <= cpc_pkg::CrcPolyReset;
            r_kind_ids     <= '0;
            r_kind_lengths <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                cpc_pkg::CFG_CRC_POLY:     r_crc_poly     <= i_cfg_data[cpc_pkg::CrcW-1:0];
                cpc_pkg::CFG_KIND_IDS:     r_kind_ids     <= i_cfg_data;
                cpc_pkg::CFG_KIND_LENGTHS: r_kind_lengths <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    assign o_pending = r_in_valid && r_in_last;

    // Next packet state for the byte in the input register.  The CRC runs two
    // bytes behind, so the trailer never enters it.
    always_comb begin
        n_first = (r_count == '0) ? r_in_byte : r_first;
        n_crc   = (r_count >= 9'd2) ?
                  cpc_pkg::crc_feed(r_crc, r_held0, r_crc_poly) : r_crc;
        n_count = (r_count < cpc_pkg::CountMax) ? r_count + 9'd1 : r_count;
    end

    // Kind match against the configured IDs; the lowest index wins.
    always_comb begin
        kind_found = 1'b0;
        kind_idx   = '0;
        for (int k = cpc_pkg::NumKinds - 1; k >= 0; k--) begin
            if (r_kind_ids[k*cpc_pkg::ByteW +: cpc_pkg::ByteW] == n_first) begin
                kind_found = 1'b1;
                kind_idx   = cpc_pkg::KindW'(k);
            end
        end
    end

    always_comb begin
        kind_len = '0;
        for (int k = 0; k < cpc_pkg::NumKinds; k++) begin
            if (kind_idx == cpc_pkg::KindW'(k)) begin
                kind_len = r_kind_lengths[k*cpc_pkg::ByteW +: cpc_pkg::ByteW];
            end
        end
    end

    // Trailer check: the byte before the last carries the CRC high byte.
    assign crc_match = (n_crc[15:8] == r_held1) && (n_crc[7:0] == r_in_byte);

    // Status in priority order.
    always_comb begin
        if (n_count < 9'd2) begin
            status = cpc_pkg::ST_SHORT;
        end else if (n_count > cpc_pkg::LengthMax) begin
            status = cpc_pkg::ST_OVERSIZE;
        end else if (!crc_match) begin
            status = cpc_pkg::ST_CRC;
        end else if (!kind_found) begin
            status = cpc_pkg::ST_UNKNOWN;
        end else if ({1'b0, kind_len} != n_count) begin
            status = cpc_pkg::ST_LENGTH;
        end else begin
            status = cpc_pkg::ST_OK;
        end
    end

    always_comb begin
        o_push                 = r_in_valid && r_in_last;
        o_result.status        = status;
        o_result.packet_kind   = kind_idx;
        o_result.packet_length = (n_count > cpc_pkg::LengthMax) ?
                                 cpc_pkg::ByteMask : n_count[cpc_pkg::ByteW-1:0];
        o_result.id_byte       = n_first;
        o_result.computed_crc  = {n_crc[7:0], n_crc[15:8]};
    end

    // Packet state update; everything clears after the final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= '0;
            r_count <= '0;
            r_held0 <= '0;
            r_held1 <= '0;
            r_first <= '0;
        end else if (r_in_valid) begin
            if (r_in_last) begin
                r_crc   <= '0;
                r_count <= '0;
                r_held0 <= '0;
                r_held1 <= '0;
                r_first <= '0;
            end else begin
                r_crc   <= n_crc;
                r_count <= n_count;
                r_held0 <= r_held1;
                r_held1 <= r_in_byte;
                r_first <= n_first;
            end
        end
    end

    // A finished packet leaves a clean state behind it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last) |=> (r_count == '0 && r_crc == '0 && r_first == '0))
        else $error("packet state not cleared after final byte");

    // An oversize packet always reports the saturated length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.status == cpc_pkg::ST_OVERSIZE) |->
        (o_result.packet_length == cpc_pkg::ByteMask))
        else $error("oversize result without saturated length");

endmodule

`default_nettype wire

// ===== rtl/cpc_out_fifo.sv =====
`default_nettype none

module cpc_out_fifo (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  cpc_pkg::t_result  i_result,
    output logic              o_valid,
    input  wire               i_ready,
    output cpc_pkg::t_result  o_result,
    output logic [2:0]        o_count
);

    // Four-entry result queue; it decouples the engine from output stalls.
    cpc_pkg::t_result r_mem [4];
    logic [1:0]       r_wr_ptr;
    logic [1:0]       r_rd_ptr;
    logic [2:0]       r_count;
    logic             pop;

    assign pop      = (r_count != 3'd0) && i_ready;
    assign o_valid  = (r_count != 3'd0);
    assign o_result = r_mem[r_rd_ptr];
    assign o_count  = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 3'd1;
                2'b01:   r_count <= r_count - 3'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // The credit check upstream must never let a result land in a full queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == 3'd4 && !pop))
        else $error("result queue overflow");

    // Occupancy stays within the queue depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/crc_checked_packet_classifier.sv =====
// A final byte that is accepted is held in the input register; its result is pushed
// from there into the result queue, which offers it on the output port.
// Throughput: one byte per cycle; the result queue holds four transactions, and
// input ready drops only when queued plus in-flight results would fill it.
// Reset (synchronous, active low) clears the packet state and the queue and
// loads the polynomial register with 0x8408 and both kind registers with zero.
`default_nettype none

module crc_checked_packet_classifier (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Configuration port.
    input  wire                            i_cfg_wr_en,
    input  wire  [1:0]                     i_cfg_index,
    input  wire  [cpc_pkg::CfgW-1:0]       i_cfg_data,
    // Byte stream in.
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [cpc_pkg::ByteW-1:0]      s_axis_tdata,   // [7:0] data_byte
    input  wire                            s_axis_tlast,
    // Result stream out.
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // [2:0] status, [5:3] packet_kind, [13:6] packet_length, [21:14] id_byte,
    // [37:22] computed_crc, [39:38] zero
    output logic [cpc_pkg::OutDataW-1:0]   m_axis_tdata
);

    logic              in_accept;
    logic              pending;
    logic              push;
    cpc_pkg::t_result  eng_result;
    cpc_pkg::t_result  q_result;
    logic [2:0]        q_count;

    // Room must remain for the in-flight final byte and the one accepted now.
    assign s_axis_tready = ({1'b0, q_count} + {3'd0, pending}) <= 4'd3;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    cpc_frame_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_accept (in_accept),
        .i_in_byte   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .o_pending   (pending),
        .o_push      (push),
        .o_result    (eng_result)
    );

    cpc_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (eng_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (q_result),
        .o_count  (q_count)
    );

    assign m_axis_tdata = {{(cpc_pkg::OutDataW - cpc_pkg::ResultW){1'b0}}, q_result};

endmodule

`default_nettype wire

// ===== test/crc_checked_packet_classifier_tb.sv =====
`timescale 1ns / 100ps

module crc_checked_packet_classifier_tb;

    // Run limits and settling time after the last expected result.
    localparam int unsigned CycleLimit   = 400000;
    localparam int unsigned SettleCycles = 4;
    localparam int unsigned ItemsPerPhase = 100;
    localparam int unsigned NumPhases     = 8;

    // Register index outside the defined set; the block must ignore it.
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum logic [1:0] {
        ROW_BYTES,
        ROW_WRITE
    } t_row_kind;

    typedef enum logic [1:0] {
        SRC_LITERAL,
        SRC_CRC_HI,
        SRC_CRC_LO
    } t_byte_src;

    // One row of the directed table: a run of bytes or a register write.
    typedef struct {
        t_row_kind                kind;
        t_byte_src                src;
        logic [1:0]               index;
        logic [cpc_pkg::CfgW-1:0] value;
        bit                       last;
        int unsigned              reps;
        bit                       typed;
        cpc_pkg::t_result         want;
    } t_stim_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_wr_en;
    logic [1:0]                   i_cfg_index;
    logic [cpc_pkg::CfgW-1:0]     i_cfg_data;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [cpc_pkg::ByteW-1:0]    s_axis_tdata;   // [7:0] data_byte
    logic                         s_axis_tlast;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    // [2:0] status, [5:3] packet_kind, [13:6] packet_length, [21:14] id_byte,
    // [37:22] computed_crc, [39:38] zero
    logic [cpc_pkg::OutDataW-1:0] m_axis_tdata;

    // Shadow copy of the configuration registers.
    logic [cpc_pkg::CrcW-1:0] cfg_poly;
    logic [cpc_pkg::CfgW-1:0] cfg_ids;
    logic [cpc_pkg::CfgW-1:0] cfg_lengths;

    // Predicted packet state.
    logic [cpc_pkg::CrcW-1:0]   pkt_crc;
    logic [cpc_pkg::CountW-1:0] pkt_count;
    logic [cpc_pkg::ByteW-1:0]  pkt_held [2];
    logic [cpc_pkg::ByteW-1:0]  pkt_first;

    cpc_pkg::t_result pending_results [$];
    t_stim_row        directed_rows [$];
    int unsigned      send_idle_pct;
    int unsigned      stall_pct;
    int unsigned      error_count;
    int unsigned      cycle_count;
    int unsigned      bytes_sent;
    int unsigned      packets_sent;
    int unsigned      results_seen;
    int unsigned      settings_used;
    int unsigned      status_seen [6];

    crc_checked_packet_classifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Reflected CRC-16 update, one data bit at a time, least significant first.
    function automatic logic [cpc_pkg::CrcW-1:0] crc_step(
        input logic [cpc_pkg::CrcW-1:0]  crc_in,
        input logic [cpc_pkg::ByteW-1:0] data,
        input logic [cpc_pkg::CrcW-1:0]  poly
    );
        logic [cpc_pkg::CrcW-1:0] crc;
        logic                     feedback;
        crc = crc_in;
        for (int i = 0; i < cpc_pkg::ByteW; i++) begin
            feedback = crc[0] ^ data[i];
            crc = crc >> 1;
            if (feedback) begin
                crc = crc ^ poly;
            end
        end
        return crc;
    endfunction

    function automatic cpc_pkg::t_result make_result(
        input cpc_pkg::t_status          st,
        input logic [cpc_pkg::KindW-1:0] kind,
        input logic [cpc_pkg::ByteW-1:0] len,
        input logic [cpc_pkg::ByteW-1:0] id,
        input logic [cpc_pkg::CrcW-1:0]  crc
    );
        cpc_pkg::t_result res;
        res.status        = st;
        res.packet_kind   = kind;
        res.packet_length = len;
        res.id_byte       = id;
        res.computed_crc  = crc;
        return res;
    endfunction

    // Advances the packet state by one accepted byte; returns 1 and the
    // classification when the byte closes the packet.
    function automatic bit classify_byte(
        input  logic [cpc_pkg::ByteW-1:0] b,
        input  bit                        lst,
        output cpc_pkg::t_result          res
    );
        logic [cpc_pkg::KindW-1:0] kind;
        logic [cpc_pkg::ByteW-1:0] klen;
        bit                        found;
        cpc_pkg::t_status          st;
        int                        k;
        res = '0;
        if (pkt_count == 0) begin
            pkt_first = b;
        end
        if (pkt_count >= 2) begin
            pkt_crc = crc_step(pkt_crc, pkt_held[0], cfg_poly);
        end
        pkt_held[0] = pkt_held[1];
        pkt_held[1] = b;
        if (pkt_count != cpc_pkg::CountMax) begin
            pkt_count = pkt_count + 9'd1;
        end
        if (!lst) begin
            return 1'b0;
        end

        // Scan from the top so that the lowest matching kind is kept.
        found = 1'b0;
        kind  = '0;
        for (k = cpc_pkg::NumKinds - 1; k >= 0; k--) begin
            if (cfg_ids[8*k +: 8] == pkt_first) begin
                found = 1'b1;
                kind  = k[cpc_pkg::KindW-1:0];
            end
        end
        klen = cfg_lengths[8*kind +: 8];

        if (pkt_count < 2) begin
            st = cpc_pkg::ST_SHORT;
        end else if (pkt_count > cpc_pkg::LengthMax) begin
            st = cpc_pkg::ST_OVERSIZE;
        end else if (pkt_crc != {pkt_held[0], pkt_held[1]}) begin
            st = cpc_pkg::ST_CRC;
        end else if (!found) begin
            st = cpc_pkg::ST_UNKNOWN;
        end else if ({1'b0, klen} != pkt_count) begin
            st = cpc_pkg::ST_LENGTH;
        end else begin
            st = cpc_pkg::ST_OK;
        end

        res = make_result(st, kind,
                          (pkt_count > cpc_pkg::LengthMax) ?
                          cpc_pkg::ByteMask : pkt_count[cpc_pkg::ByteW-1:0],
                          pkt_first, {pkt_crc[7:0], pkt_crc[15:8]});
        pkt_crc     = '0;
        pkt_count   = '0;
        pkt_held[0] = '0;
        pkt_held[1] = '0;
        pkt_first   = '0;
        return 1'b1;
    endfunction

    function automatic void compare_field(
        input string       name,
        input int unsigned want,
        input int unsigned got
    );
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Directed table builders.
    function automatic void bytes_row(
        input t_byte_src                 src,
        input logic [cpc_pkg::ByteW-1:0] value,
        input bit                        last,
        input int unsigned               reps
    );
        t_stim_row row;
        row = '{ROW_BYTES, src, 2'd0, cpc_pkg::CfgW'(value), last, reps, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void checked_row(
        input logic [cpc_pkg::ByteW-1:0] value,
        input int unsigned               reps,
        input cpc_pkg::t_result          want
    );
        t_stim_row row;
        row = '{ROW_BYTES, SRC_LITERAL, 2'd0, cpc_pkg::CfgW'(value), 1'b1, reps, 1'b1,
                want};
        directed_rows.push_back(row);
    endfunction

    function automatic void write_row(
        input logic [1:0]               index,
        input logic [cpc_pkg::CfgW-1:0] value
    );
        t_stim_row row;
        row = '{ROW_WRITE, SRC_LITERAL, index, value, 1'b0, 1, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    // Sends one byte, with random idle cycles first, and records the expected result when it closes a packet.
    task automatic push_byte(
        input logic [cpc_pkg::ByteW-1:0] b,
        input bit                        lst,
        input bit                        typed,
        input cpc_pkg::t_result          want
    );
        cpc_pkg::t_result res;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        bytes_sent++;
        if (classify_byte(b, lst, res)) begin
            packets_sent++;
            pending_results.push_back(typed ? want : res);
        end
    endtask

    // Stops sending and waits until every outstanding result has arrived.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_register(
        input logic [1:0]               index,
        input logic [cpc_pkg::CfgW-1:0] value
    );
        wait_for_drain();
        repeat (SettleCycles) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
        case (index)
            cpc_pkg::CFG_CRC_POLY:     cfg_poly    = value[cpc_pkg::CrcW-1:0];
            cpc_pkg::CFG_KIND_IDS:     cfg_ids     = value;
            cpc_pkg::CFG_KIND_LENGTHS: cfg_lengths = value;
            default: ;
        endcase
    endtask

    // One random packet: mostly a configured ID with a correct trailer, in half the draws
    // aimed at the configured length, with short, long and corrupted packets mixed in.
    task automatic send_packet();
        logic [cpc_pkg::ByteW-1:0] pid;
        logic [cpc_pkg::ByteW-1:0] b;
        logic [cpc_pkg::ByteW-1:0] mask_hi;
        logic [cpc_pkg::ByteW-1:0] mask_lo;
        logic [cpc_pkg::CrcW-1:0]  gen;
        int unsigned               k;
        int unsigned               r;
        int unsigned               len;
        k   = $urandom_range(cpc_pkg::NumKinds - 1);
        pid = ($urandom_range(99) < 85) ? cfg_ids[8*k +: 8] : 8'($urandom);
        r   = $urandom_range(99);
        if (r < 50) begin
            len = cfg_lengths[8*k +: 8];
            if (len < 2 || (len > 40 && $urandom_range(9) != 0)) begin
                len = $urandom_range(12, 2);
            end
        end else if (r < 53) begin
            case ($urandom_range(2))
                0:       len = 255;
                1:       len = 256;
                default: len = $urandom_range(520, 200);
            endcase
        end else if (r < 60) begin
            len = 1;
        end else begin
            len = $urandom_range(16, 2);
        end
        if ($urandom_range(99) < 12) begin
            mask_hi = 8'($urandom);
            mask_lo = 8'($urandom);
        end else begin
            mask_hi = '0;
            mask_lo = '0;
        end

        gen = '0;
        for (int i = 0; i < len; i++) begin
            if (i + 2 < len) begin
                b   = (i == 0) ? pid : 8'($urandom);
                gen = crc_step(gen, b, cfg_poly);
            end else if (len == 1) begin
                b = pid;
            end else if (i + 2 == len) begin
                b = gen[15:8] ^ mask_hi;
            end else begin
                b = gen[7:0] ^ mask_lo;
            end
            push_byte(b, i == len - 1, 1'b0, '0);
        end
    endtask

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Result checking against the oldest outstanding expectation.
    always @(posedge i_clk) begin : result_check
        cpc_pkg::t_result got;
        cpc_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = cpc_pkg::t_result'(m_axis_tdata[cpc_pkg::ResultW-1:0]);
            results_seen++;
            if (got.status <= cpc_pkg::ST_OVERSIZE) begin
                status_seen[got.status]++;
            end
            if (pending_results.size() == 0) begin
                $error("result with no packet outstanding: tdata 0x%h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", want.status, got.status);
                compare_field("packet_kind", want.packet_kind, got.packet_kind);
                compare_field("packet_length", want.packet_length, got.packet_length);
                compare_field("id_byte", want.id_byte, got.id_byte);
                compare_field("computed_crc", want.computed_crc, got.computed_crc);
                compare_field("tdata padding", 0,
                              m_axis_tdata[cpc_pkg::OutDataW-1:cpc_pkg::ResultW]);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("crc_checked_packet_classifier: mismatch");
            $finish;
        end
    end

    // Main stimulus.
    initial begin : stimulus
        logic [cpc_pkg::CrcW-1:0]  gen;
        logic [cpc_pkg::ByteW-1:0] b;
        logic [63:0]               wide;
        logic [cpc_pkg::CrcW-1:0]  poly;
        logic [cpc_pkg::CfgW-1:0]  ids;
        logic [cpc_pkg::CfgW-1:0]  lengths;
        int unsigned               phase_start;
        t_stim_row                 row;

        error_count   = 0;
        cycle_count   = 0;
        bytes_sent    = 0;
        packets_sent  = 0;
        results_seen  = 0;
        settings_used = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        foreach (status_seen[i]) status_seen[i] = 0;

        cfg_poly    = cpc_pkg::CrcPolyReset;
        cfg_ids     = '0;
        cfg_lengths = '0;
        pkt_crc     = '0;
        pkt_count   = '0;
        pkt_held[0] = '0;
        pkt_held[1] = '0;
        pkt_first   = '0;

        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: polynomial 0x8408, every ID and every length zero.
        // All-zero packets keep the CRC at zero, so their results are plain.
        checked_row(8'hFF, 1,
                    make_result(cpc_pkg::ST_SHORT, 3'd0, 8'd1, 8'hFF, 16'h0000));
        checked_row(8'h00, 1,
                    make_result(cpc_pkg::ST_SHORT, 3'd0, 8'd1, 8'h00, 16'h0000));
        checked_row(8'h00, 2,
                    make_result(cpc_pkg::ST_LENGTH, 3'd0, 8'd2, 8'h00, 16'h0000));
        bytes_row(SRC_LITERAL, 8'h00, 1'b0, 1);
        checked_row(8'h01, 1,
                    make_result(cpc_pkg::ST_CRC, 3'd0, 8'd2, 8'h00, 16'h0000));
        checked_row(8'h00, 255,
                    make_result(cpc_pkg::ST_LENGTH, 3'd0, 8'd255, 8'h00, 16'h0000));
        checked_row(8'h00, 256,
                    make_result(cpc_pkg::ST_OVERSIZE, 3'd0, 8'd255, 8'h00, 16'h0000));
        // Oversize wins over a bad trailer and an unknown ID.
        bytes_row(SRC_LITERAL, 8'hFF, 1'b1, 300);

        // Duplicate ID 0x22 at kinds 1 and 3; the write to the spare index
        // must leave everything as it was.
        write_row(cpc_pkg::CFG_KIND_IDS, 40'h33_22_44_22_00);
        write_row(cpc_pkg::CFG_KIND_LENGTHS, 40'h05_04_03_03_02);
        write_row(CFG_UNUSED_INDEX, '1);
        checked_row(8'h00, 2,
                    make_result(cpc_pkg::ST_OK, 3'd0, 8'd2, 8'h00, 16'h0000));
        bytes_row(SRC_LITERAL, 8'h22, 1'b0, 1);
        bytes_row(SRC_CRC_HI, 8'h00, 1'b0, 1);
        bytes_row(SRC_CRC_LO, 8'h00, 1'b1, 1);
        bytes_row(SRC_LITERAL, 8'h33, 1'b0, 1);
        bytes_row(SRC_CRC_HI, 8'h00, 1'b0, 1);
        bytes_row(SRC_CRC_LO, 8'h00, 1'b1, 1);
        bytes_row(SRC_LITERAL, 8'h55, 1'b0, 1);
        bytes_row(SRC_CRC_HI, 8'h00, 1'b0, 1);
        bytes_row(SRC_CRC_LO, 8'h00, 1'b1, 1);
        write_row(cpc_pkg::CFG_CRC_POLY, 40'h0);
        bytes_row(SRC_LITERAL, 8'h44, 1'b0, 1);
        bytes_row(SRC_LITERAL, 8'h5A, 1'b0, 1);
        bytes_row(SRC_CRC_HI, 8'h00, 1'b0, 1);
        bytes_row(SRC_CRC_LO, 8'h00, 1'b1, 1);

        // Walk the table; trailer rows take the CRC of the literal bytes so far.
        gen = '0;
        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.kind == ROW_WRITE) begin
                write_register(row.index, row.value);
            end else begin
                for (int r = 0; r < row.reps; r++) begin
                    case (row.src)
                        SRC_CRC_HI: b = gen[15:8];
                        SRC_CRC_LO: b = gen[7:0];
                        default: begin
                            b   = row.value[cpc_pkg::ByteW-1:0];
                            gen = crc_step(gen, b, cfg_poly);
                        end
                    endcase
                    push_byte(b, row.last && r == row.reps - 1, row.typed, row.want);
                    if (row.last && r == row.reps - 1) begin
                        gen = '0;
                    end
                end
            end
        end

        // Random phases, each with fresh settings and one of four idling patterns.
        for (int phase_num = 0; phase_num < NumPhases; phase_num++) begin
            poly    = 16'($urandom);
            wide    = {$urandom, $urandom};
            ids     = wide[cpc_pkg::CfgW-1:0];
            for (int k = 0; k < cpc_pkg::NumKinds; k++) begin
                lengths[8*k +: 8] = 8'($urandom_range(12, 2));
            end
            case (phase_num)
                0: poly = cpc_pkg::CrcPolyReset;
                1: begin
                    poly    = '0;
                    ids     = '0;
                    lengths = '0;
                end
                2: begin
                    poly    = '1;
                    ids     = '1;
                    lengths = '1;
                end
                3: begin
                    ids[31:24] = ids[7:0];
                    ids[39:32] = ids[15:8];
                end
                4: begin
                    wide    = {$urandom, $urandom};
                    lengths = wide[cpc_pkg::CfgW-1:0];
                end
                default: ;
            endcase
            write_register(cpc_pkg::CFG_CRC_POLY, cpc_pkg::CfgW'(poly));
            write_register(cpc_pkg::CFG_KIND_IDS, ids);
            write_register(cpc_pkg::CFG_KIND_LENGTHS, lengths);

            case (phase_num % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 81;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 81;
                end
                default: begin
                    send_idle_pct = 23;
                    stall_pct     = 23;
                end
            endcase

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < ItemsPerPhase) begin
                send_packet();
                // Now and then hold off until the result stream has caught up.
                if ($urandom_range(49) == 0) begin
                    wait_for_drain();
                end
            end
        end

        // Wind down.
        wait_for_drain();
        repeat (SettleCycles * 2) @(posedge i_clk);

        $display("Checked %0d results from %0d bytes in %0d packets over %0d register writes.",
                 results_seen, bytes_sent, packets_sent, settings_used);
        $display("Status tally: ok %0d, short %0d, crc %0d, unknown id %0d,",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("length %0d, oversize %0d.", status_seen[4], status_seen[5]);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("crc_checked_packet_classifier: match");
        end else begin
            $display("crc_checked_packet_classifier: mismatch");
        end
        $finish;
    end

endmodule

// ===== crc_checked_packet_classifier.f =====
rtl/cpc_pkg.sv
rtl/cpc_frame_engine.sv
rtl/cpc_out_fifo.sv
rtl/crc_checked_packet_classifier.sv
test/crc_checked_packet_classifier_tb.sv
